@@ design/gzhp_pkg.sv @@
// Shared types, codes and helpers for the gzip member header parser.
`default_nettype none

package gzhp_pkg;

    // Header constants
    localparam logic [7:0] MAGIC_A        = 8'h1F;
    localparam logic [7:0] MAGIC_B        = 8'h8B;
    localparam logic [7:0] METHOD_DEFLATE = 8'd8;
    localparam logic [15:0] FIXED_SKIP    = 16'd6;
    localparam logic [15:0] HCRC_SKIP     = 16'd2;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // FLG bit positions
    localparam int FLG_HCRC_BIT    = 1;
    localparam int FLG_EXTRA_BIT   = 2;
    localparam int FLG_NAME_BIT    = 3;
    localparam int FLG_COMMENT_BIT = 4;
    localparam logic [7:0] FLG_RESERVED = 8'hE0;

    // Output class of a word; also used as the sticky reject code
    typedef enum logic [1:0] {
        CLS_HEADER     = 2'd0,
        CLS_PAYLOAD    = 2'd1,
        CLS_BAD_MAGIC  = 2'd2,
        CLS_BAD_METHOD = 2'd3
    } cls_t;

    // Header walk phases, one-hot
    typedef enum logic [11:0] {
        PH_MAGIC_A = 12'b0000_0000_0001,
        PH_MAGIC_B = 12'b0000_0000_0010,
        PH_METHOD  = 12'b0000_0000_0100,
        PH_FLAGS   = 12'b0000_0000_1000,
        PH_FIXED   = 12'b0000_0001_0000,
        PH_XLEN_LO = 12'b0000_0010_0000,
        PH_XLEN_HI = 12'b0000_0100_0000,
        PH_XDATA   = 12'b0000_1000_0000,
        PH_NAME    = 12'b0001_0000_0000,
        PH_COMMENT = 12'b0010_0000_0000,
        PH_HCRC    = 12'b0100_0000_0000,
        PH_PAYLOAD = 12'b1000_0000_0000
    } phase_t;

    // Earliest optional section to consider when moving on
    typedef enum logic [1:0] {
        FROM_EXTRA   = 2'd0,
        FROM_NAME    = 2'd1,
        FROM_COMMENT = 2'd2,
        FROM_HCRC    = 2'd3
    } from_t;

    // One input word
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } item_t;

    // One result word
    typedef struct packed {
        cls_t        cls;
        logic [7:0]  data;
        logic [15:0] hlen;
    } result_t;

    // First section at or after 'from' that the flags call for
    function automatic phase_t next_section(input logic [7:0] flags, input from_t from);
        phase_t ph;
        ph = PH_PAYLOAD;
        if (flags[FLG_HCRC_BIT])
            ph = PH_HCRC;
        if (from <= FROM_COMMENT && flags[FLG_COMMENT_BIT])
            ph = PH_COMMENT;
        if (from <= FROM_NAME && flags[FLG_NAME_BIT])
            ph = PH_NAME;
        if (from == FROM_EXTRA && flags[FLG_EXTRA_BIT])
            ph = PH_XLEN_LO;
        return ph;
    endfunction

endpackage

`default_nettype wire

@@ design/gzhp_in_stage.sv @@
// Input register stage: holds one incoming word until the walker takes it.
`default_nettype none

module gzhp_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire gzhp_pkg::item_t in_item,
    output logic                s_valid,
    input  wire logic           s_ready,
    output gzhp_pkg::item_t     s_item
);

    logic            valid_reg;
    gzhp_pkg::item_t item_reg;

    // Free when empty or when the held word moves on this cycle
    assign in_ready = !valid_reg || s_ready;
    assign s_valid  = valid_reg;
    assign s_item   = item_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

endmodule

`default_nettype wire

@@ design/gzhp_walker.sv @@
// Header walk state and the per-word step logic.
`default_nettype none

module gzhp_walker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire gzhp_pkg::item_t item,
    output gzhp_pkg::result_t    result
);

    gzhp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       flags_reg, flags_next;
    logic [15:0]      skip_reg, skip_next;
    logic [15:0]      count_reg, count_next;
    gzhp_pkg::cls_t   rej_reg, rej_next;

    gzhp_pkg::phase_t eff_phase;
    logic [7:0]       eff_flags;
    logic [15:0]      eff_skip;
    logic [15:0]      eff_count;
    gzhp_pkg::cls_t   eff_rej;
    logic [15:0]      skip_dec;
    logic [15:0]      xlen;
    gzhp_pkg::cls_t   cls;
    logic [7:0]       b;

    assign b = item.data;

    // Stream start restarts from the reset state
    always_comb
    begin
        eff_phase = item.start ? gzhp_pkg::PH_MAGIC_A : phase_reg;
        eff_flags = item.start ? 8'd0 : flags_reg;
        eff_skip  = item.start ? 16'd0 : skip_reg;
        eff_count = item.start ? 16'd0 : count_reg;
        eff_rej   = item.start ? gzhp_pkg::CLS_HEADER : rej_reg;
    end

    assign skip_dec = (eff_skip != 16'd0) ? (eff_skip - 16'd1) : 16'd0;
    assign xlen     = eff_skip | {b, 8'h00};

    // One step of the header walk
    always_comb
    begin
        phase_next = eff_phase;
        flags_next = eff_flags;
        skip_next  = eff_skip;
        count_next = eff_count;
        rej_next   = eff_rej;
        cls        = gzhp_pkg::CLS_HEADER;
        if (eff_rej != gzhp_pkg::CLS_HEADER) begin
            cls = eff_rej;
        end else if (eff_phase == gzhp_pkg::PH_PAYLOAD) begin
            cls = gzhp_pkg::CLS_PAYLOAD;
        end else begin
            case (eff_phase)
                gzhp_pkg::PH_MAGIC_A:
                begin
                    if (b != gzhp_pkg::MAGIC_A) rej_next = gzhp_pkg::CLS_BAD_MAGIC;
                    else phase_next = gzhp_pkg::PH_MAGIC_B;
                end
                gzhp_pkg::PH_MAGIC_B:
                begin
                    if (b != gzhp_pkg::MAGIC_B) rej_next = gzhp_pkg::CLS_BAD_MAGIC;
                    else phase_next = gzhp_pkg::PH_METHOD;
                end
                gzhp_pkg::PH_METHOD:
                begin
                    if (b != gzhp_pkg::METHOD_DEFLATE) rej_next = gzhp_pkg::CLS_BAD_METHOD;
                    else phase_next = gzhp_pkg::PH_FLAGS;
                end
                gzhp_pkg::PH_FLAGS:
                begin
                    if ((b & gzhp_pkg::FLG_RESERVED) != 8'd0) begin
                        rej_next = gzhp_pkg::CLS_BAD_METHOD;
                    end else begin
                        flags_next = b;
                        skip_next  = gzhp_pkg::FIXED_SKIP;
                        phase_next = gzhp_pkg::PH_FIXED;
                    end
                end
                gzhp_pkg::PH_FIXED:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = gzhp_pkg::next_section(eff_flags, gzhp_pkg::FROM_EXTRA);
                end
                gzhp_pkg::PH_XDATA:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = gzhp_pkg::next_section(eff_flags, gzhp_pkg::FROM_NAME);
                end
                gzhp_pkg::PH_XLEN_LO:
                begin
                    skip_next  = {8'd0, b};
                    phase_next = gzhp_pkg::PH_XLEN_HI;
                end
                gzhp_pkg::PH_XLEN_HI:
                begin
                    skip_next = xlen;
                    if (xlen == 16'd0)
                        phase_next = gzhp_pkg::next_section(eff_flags, gzhp_pkg::FROM_NAME);
                    else
                        phase_next = gzhp_pkg::PH_XDATA;
                end
                gzhp_pkg::PH_NAME:
                begin
                    if (b == 8'd0)
                        phase_next = gzhp_pkg::next_section(eff_flags, gzhp_pkg::FROM_COMMENT);
                end
                gzhp_pkg::PH_COMMENT:
                begin
                    if (b == 8'd0)
                        phase_next = gzhp_pkg::next_section(eff_flags, gzhp_pkg::FROM_HCRC);
                end
                gzhp_pkg::PH_HCRC:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                        phase_next = gzhp_pkg::PH_PAYLOAD;
                end
                default:
                begin
                    phase_next = gzhp_pkg::PH_PAYLOAD;
                end
            endcase
            // Entering the header CRC loads its two-byte skip
            if (phase_next == gzhp_pkg::PH_HCRC && eff_phase != gzhp_pkg::PH_HCRC)
                skip_next = gzhp_pkg::HCRC_SKIP;
            // Rejecting word is not counted
            if (rej_next != gzhp_pkg::CLS_HEADER)
                cls = rej_next;
            else if (eff_count != gzhp_pkg::COUNT_MAX)
                count_next = eff_count + 16'd1;
        end
    end

    assign result.cls  = cls;
    assign result.data = b;
    assign result.hlen = count_next;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= gzhp_pkg::PH_MAGIC_A;
            flags_reg <= 8'd0;
            skip_reg  <= 16'd0;
            count_reg <= 16'd0;
            rej_reg   <= gzhp_pkg::CLS_HEADER;
        end else if (fire) begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            skip_reg  <= skip_next;
            count_reg <= count_next;
            rej_reg   <= rej_next;
        end
    end

    // A reject holds until the next stream start
    a_reject_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.start && rej_reg != gzhp_pkg::CLS_HEADER)
            |=> (rej_reg == $past(rej_reg) && count_reg == $past(count_reg)))
        else $error("reject code or count changed without stream start");

    // Header count only grows within a stream
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.start) |=> (count_reg >= $past(count_reg)))
        else $error("header count went down within a stream");

    // CRC skip stays within its two bytes
    a_hcrc_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == gzhp_pkg::PH_HCRC) |-> (skip_reg == 16'd1 || skip_reg == 16'd2))
        else $error("header CRC skip count out of range");

endmodule

`default_nettype wire

@@ design/gzip_header_parser.sv @@
// Top level of the gzip member header parser: input stage, walker, result register.
//
//  channel | direction | handshake             | fields
//  --------+-----------+-----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready   | data_in, stream_start
//  out     | output    | out_valid / out_ready | byte_class, data_out, header_length
//
// One word per cycle sustained while out_ready stays high; a word passes the input register,
// then the walker step into the result register, before out_valid rises.
// The walker step is one pass of the phase machine, so the walker never holds the rate below one.
// Reset (rst_n low) empties both registers and returns the walk to the first magic byte.
// A stalled output holds the result; the input register then fills and in_ready drops.
`default_nettype none

module gzip_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_in,
    input  wire logic        stream_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       byte_class,
    output logic [7:0]       data_out,
    output logic [15:0]      header_length
);

    gzhp_pkg::item_t   in_item;
    gzhp_pkg::item_t   s_item;
    gzhp_pkg::result_t step_res;
    logic              s_valid;
    logic              s_ready;
    logic              fire;

    logic              out_valid_reg;
    gzhp_pkg::result_t res_reg;

    assign in_item.data  = data_in;
    assign in_item.start = stream_start;

    gzhp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item)
    );

    // Step when the result register is free or draining
    assign s_ready = !out_valid_reg || out_ready;
    assign fire    = s_valid && s_ready;

    gzhp_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s_item),
        .result (step_res)
    );

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_ready)
            out_valid_reg <= s_valid;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= step_res;
    end

    assign out_valid     = out_valid_reg;
    assign byte_class    = res_reg.cls;
    assign data_out      = res_reg.data;
    assign header_length = res_reg.hlen;

endmodule

`default_nettype wire

@@ dv/tb_gzip_header_parser.sv @@
// Testbench for gzip_header_parser: directed and random byte streams checked against a predictor.
`default_nettype none

module tb_gzip_header_parser;

    localparam int ITEM_TARGET = 1550;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_PRINTED = 40;
    localparam int HOLD_CYCLES = 80;
    localparam int NONE = -1;

    localparam logic [7:0] NUL          = 8'h00;
    localparam logic [7:0] FLAG_HCRC    = 8'h01 << gzhp_pkg::FLG_HCRC_BIT;
    localparam logic [7:0] FLAG_EXTRA   = 8'h01 << gzhp_pkg::FLG_EXTRA_BIT;
    localparam logic [7:0] FLAG_NAME    = 8'h01 << gzhp_pkg::FLG_NAME_BIT;
    localparam logic [7:0] FLAG_COMMENT = 8'h01 << gzhp_pkg::FLG_COMMENT_BIT;
    localparam logic [7:0] FLAG_TEXT    = 8'h01;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_in;
    logic        stream_start;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  byte_class;
    logic [7:0]  data_out;
    logic [15:0] header_length;

    // Predictor copy of the header walk
    gzhp_pkg::phase_t walk_phase;
    logic [7:0]       walk_flags;
    logic [15:0]      walk_skip;
    logic [15:0]      walk_count;
    gzhp_pkg::cls_t   walk_reject;

    gzhp_pkg::result_t expected_q[$];
    int          error_count;
    int          words_sent;
    int          stall_cycles;
    int          rx_gap;
    logic        no_idle;
    logic        rx_hold;

    gzip_header_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_in       (data_in),
        .stream_start  (stream_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_class    (byte_class),
        .data_out      (data_out),
        .header_length (header_length)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void reset_walk();
        walk_phase  = gzhp_pkg::PH_MAGIC_A;
        walk_flags  = '0;
        walk_skip   = '0;
        walk_count  = '0;
        walk_reject = gzhp_pkg::CLS_HEADER;
    endfunction

    // First optional section at or after start_at that the flags ask for
    function automatic gzhp_pkg::phase_t pick_section(input gzhp_pkg::phase_t start_at);
        if (start_at <= gzhp_pkg::PH_XLEN_LO && walk_flags[gzhp_pkg::FLG_EXTRA_BIT])
            return gzhp_pkg::PH_XLEN_LO;
        if (start_at <= gzhp_pkg::PH_NAME && walk_flags[gzhp_pkg::FLG_NAME_BIT])
            return gzhp_pkg::PH_NAME;
        if (start_at <= gzhp_pkg::PH_COMMENT && walk_flags[gzhp_pkg::FLG_COMMENT_BIT])
            return gzhp_pkg::PH_COMMENT;
        if (start_at <= gzhp_pkg::PH_HCRC && walk_flags[gzhp_pkg::FLG_HCRC_BIT])
        begin
            walk_skip = gzhp_pkg::HCRC_SKIP;
            return gzhp_pkg::PH_HCRC;
        end
        return gzhp_pkg::PH_PAYLOAD;
    endfunction

    // Step the header walk by one byte and queue the expected result word
    function automatic void predict_word(input logic [7:0] b, input logic s);
        gzhp_pkg::cls_t    cls;
        gzhp_pkg::result_t want;
        if (s)
            reset_walk();
        cls = gzhp_pkg::CLS_HEADER;
        if (walk_reject != gzhp_pkg::CLS_HEADER)
            cls = walk_reject;
        else if (walk_phase == gzhp_pkg::PH_PAYLOAD)
            cls = gzhp_pkg::CLS_PAYLOAD;
        else
        begin
            case (walk_phase)
                gzhp_pkg::PH_MAGIC_A:
                    if (b != gzhp_pkg::MAGIC_A) walk_reject = gzhp_pkg::CLS_BAD_MAGIC;
                    else walk_phase = gzhp_pkg::PH_MAGIC_B;
                gzhp_pkg::PH_MAGIC_B:
                    if (b != gzhp_pkg::MAGIC_B) walk_reject = gzhp_pkg::CLS_BAD_MAGIC;
                    else walk_phase = gzhp_pkg::PH_METHOD;
                gzhp_pkg::PH_METHOD:
                    if (b != gzhp_pkg::METHOD_DEFLATE) walk_reject = gzhp_pkg::CLS_BAD_METHOD;
                    else walk_phase = gzhp_pkg::PH_FLAGS;
                gzhp_pkg::PH_FLAGS:
                    if ((b & gzhp_pkg::FLG_RESERVED) != '0)
                        walk_reject = gzhp_pkg::CLS_BAD_METHOD;
                    else
                    begin
                        walk_flags = b;
                        walk_skip  = gzhp_pkg::FIXED_SKIP;
                        walk_phase = gzhp_pkg::PH_FIXED;
                    end
                gzhp_pkg::PH_FIXED, gzhp_pkg::PH_XDATA:
                begin
                    if (walk_skip != '0)
                        walk_skip = walk_skip - 16'd1;
                    if (walk_skip == '0)
                        walk_phase = pick_section(walk_phase == gzhp_pkg::PH_FIXED ?
                                                  gzhp_pkg::PH_XLEN_LO : gzhp_pkg::PH_NAME);
                end
                gzhp_pkg::PH_XLEN_LO:
                begin
                    walk_skip  = {8'h00, b};
                    walk_phase = gzhp_pkg::PH_XLEN_HI;
                end
                gzhp_pkg::PH_XLEN_HI:
                begin
                    walk_skip  = {b, walk_skip[7:0]};
                    walk_phase = (walk_skip == '0) ? pick_section(gzhp_pkg::PH_NAME)
                                                   : gzhp_pkg::PH_XDATA;
                end
                gzhp_pkg::PH_NAME:
                    if (b == NUL) walk_phase = pick_section(gzhp_pkg::PH_COMMENT);
                gzhp_pkg::PH_COMMENT:
                    if (b == NUL) walk_phase = pick_section(gzhp_pkg::PH_HCRC);
                default:
                begin
                    // header CRC bytes
                    if (walk_skip != '0)
                        walk_skip = walk_skip - 16'd1;
                    if (walk_skip == '0)
                        walk_phase = gzhp_pkg::PH_PAYLOAD;
                end
            endcase
            // the rejecting byte is not counted
            if (walk_reject != gzhp_pkg::CLS_HEADER)
                cls = walk_reject;
            else if (walk_count != gzhp_pkg::COUNT_MAX)
                walk_count = walk_count + 16'd1;
        end
        want.cls  = cls;
        want.data = b;
        want.hlen = walk_count;
        expected_q.push_back(want);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        gzhp_pkg::result_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch("word with nothing expected, data_out", data_out, 0);
            return;
        end
        want = expected_q.pop_front();
        if (byte_class !== want.cls)
            report_mismatch("byte_class", byte_class, want.cls);
        if (data_out !== want.data)
            report_mismatch("data_out", data_out, want.data);
        if (header_length !== want.hlen)
            report_mismatch("header_length", header_length, want.hlen);
    endtask

    // Receiver: random gap per word, plus the long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_result();
            rx_gap = no_idle ? 0 : $urandom_range(0, 3);
        end
        if (rx_hold)
            out_ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap = rx_gap - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Sender: one word, after a random gap; valid stays up for a back-to-back word
    task automatic send_word(input logic [7:0] d, input logic s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        predict_word(d, s);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_in      <= d;
        stream_start <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Build one gzip member, optionally with a corrupted byte or cut short
    task automatic send_member(input logic [7:0] flags, input logic [15:0] xlen,
                               input int name_len, input int cmt_len, input int pay_len,
                               input logic first_start, input int corrupt_at, input int cut_at);
        logic [7:0] bytes_q[$];
        int         n;
        bytes_q.push_back(gzhp_pkg::MAGIC_A);
        bytes_q.push_back(gzhp_pkg::MAGIC_B);
        bytes_q.push_back(gzhp_pkg::METHOD_DEFLATE);
        bytes_q.push_back(flags);
        repeat (gzhp_pkg::FIXED_SKIP) bytes_q.push_back(8'($urandom_range(0, 255)));
        if (flags[gzhp_pkg::FLG_EXTRA_BIT])
        begin
            bytes_q.push_back(xlen[7:0]);
            bytes_q.push_back(xlen[15:8]);
            repeat (xlen) bytes_q.push_back(8'($urandom_range(0, 255)));
        end
        if (flags[gzhp_pkg::FLG_NAME_BIT])
        begin
            repeat (name_len) bytes_q.push_back(8'($urandom_range(1, 255)));
            bytes_q.push_back(NUL);
        end
        if (flags[gzhp_pkg::FLG_COMMENT_BIT])
        begin
            repeat (cmt_len) bytes_q.push_back(8'($urandom_range(1, 255)));
            bytes_q.push_back(NUL);
        end
        if (flags[gzhp_pkg::FLG_HCRC_BIT])
            repeat (gzhp_pkg::HCRC_SKIP) bytes_q.push_back(8'($urandom_range(0, 255)));
        repeat (pay_len) bytes_q.push_back(8'($urandom_range(0, 255)));
        if (corrupt_at >= 0 && corrupt_at < bytes_q.size())
            bytes_q[corrupt_at] = 8'($urandom_range(0, 255));
        n = (cut_at >= 0 && cut_at < bytes_q.size()) ? cut_at : bytes_q.size();
        for (int i = 0; i < n; i++)
            send_word(bytes_q[i], (i == 0) ? first_start : 1'b0);
    endtask

    // After reset the parser expects magic without a stream start
    task automatic test_no_start_first();
        send_member(NUL, '0, 0, 0, 2, 1'b0, NONE, NONE);
    endtask

    // Each reject kind, with a trailing word to show it is sticky
    task automatic test_rejects();
        send_word(8'h00, 1'b1);
        send_word(gzhp_pkg::MAGIC_A, 1'b0);
        send_word(gzhp_pkg::MAGIC_A, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(gzhp_pkg::MAGIC_A, 1'b1);
        send_word(gzhp_pkg::MAGIC_B, 1'b0);
        send_word(gzhp_pkg::METHOD_DEFLATE + 8'd1, 1'b0);
        send_word(gzhp_pkg::METHOD_DEFLATE, 1'b0);
        send_member(8'h80, '0, 0, 0, 0, 1'b1, NONE, 5);
        send_member(8'h20, '0, 0, 0, 0, 1'b1, NONE, 5);
    endtask

    // Zero-length extra, every flag set, and a restart inside the name
    task automatic test_optional_fields();
        send_member(FLAG_EXTRA, '0, 0, 0, 1, 1'b1, NONE, NONE);
        send_member(FLAG_TEXT | FLAG_HCRC | FLAG_EXTRA | FLAG_NAME | FLAG_COMMENT,
                    16'd1, 1, 0, 2, 1'b1, NONE, NONE);
        send_member(FLAG_NAME | FLAG_COMMENT, '0, 4, 2, 0, 1'b1, NONE, 12);
        send_member(FLAG_HCRC, '0, 0, 0, 1, 1'b1, NONE, NONE);
    endtask

    // Receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            send_member(FLAG_NAME, '0, 20, 0, 10, 1'b1, NONE, NONE);
        join
    endtask

    // Extra field over 255 bytes, so both length bytes matter
    task automatic test_long_extra();
        send_member(FLAG_EXTRA | FLAG_NAME, 16'h0103, 2, 0, 3, 1'b1, NONE, NONE);
    endtask

    // Mostly well-formed members with random content, some broken ones and noise
    task automatic test_random_streams();
        int          kind;
        int          n;
        logic [7:0]  flags;
        logic [15:0] xlen;
        while (words_sent < ITEM_TARGET)
        begin
            no_idle <= ($urandom_range(0, 7) == 0);
            kind  = $urandom_range(0, 99);
            flags = 8'($urandom_range(0, 31));
            xlen  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 511))
                                                 : 16'($urandom_range(0, 12));
            if (kind < 75)
                send_member(flags, xlen, $urandom_range(0, 8), $urandom_range(0, 8),
                            $urandom_range(0, 24), $urandom_range(0, 9) != 0, NONE, NONE);
            else if (kind < 88)
                send_member(flags, xlen, $urandom_range(0, 4), $urandom_range(0, 4),
                            $urandom_range(0, 8), 1'b1, $urandom_range(0, 5), NONE);
            else if (kind < 95)
                send_member(flags, xlen, $urandom_range(0, 4), $urandom_range(0, 4),
                            $urandom_range(0, 8), 1'b1, NONE, $urandom_range(1, 14));
            else
            begin
                n = $urandom_range(1, 10);
                repeat (n) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Watchdog on cycles with no word moving on either side
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("gzip_header_parser regression: fail");
        $finish;
    end

    initial
    begin
        error_count = 0;
        words_sent  = 0;
        rx_gap      = 0;
        reset_walk();
        rst_n        = 1'b0;
        in_valid     <= 1'b0;
        data_in      <= '0;
        stream_start <= 1'b0;
        out_ready    <= 1'b0;
        no_idle      <= 1'b0;
        rx_hold      <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_no_start_first();
        test_rejects();
        test_optional_fields();
        test_backpressure();
        test_long_extra();
        test_random_streams();

        // drain, then allow for the pipeline latency
        in_valid <= 1'b0;
        while (expected_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("gzip_header_parser regression: pass");
        else
            $display("gzip_header_parser regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
